[rtl/great_circle_distance_macros.svh]
// Assertion macros for the great-circle distance RTL.
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define GCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define GCD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/gcd_pkg.sv]
// Constants, types and table functions for the great-circle distance pipeline.
package gcd_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int STEPS = (CORDIC_STEPS > 60) ? 60 : CORDIC_STEPS;
	localparam int ROOT_STEPS = 31;

	localparam longint PI48 = 64'sh0003243F6A8885A3;
	localparam longint RAD_DIV = 64'sd18000 * 64'sd524288;
	localparam longint RAD_BIAS = 64'sd9000 * 64'sd524288;
	localparam longint RAD_QUO = PI48 / RAD_DIV;
	localparam longint RAD_REM = PI48 % RAD_DIV;
	localparam longint RAD_RECIP = (64'sd34359738368 + 64'sd1124) / 64'sd1125;
	localparam longint HALF_PI = PI48 >>> 20;
	localparam longint PI_Q29 = PI48 >>> 19;
	localparam longint GAIN = 64'sh26DD3B6A;
	localparam longint DIST_BIAS = 64'sd5 * 64'sd536870912;
	localparam longint DIST_RECIP = (64'sd2097152 + 64'sd4) / 64'sd5;
	localparam logic [15:0] RADIUS_RESET = 16'd63781;
	localparam logic [15:0] DIST_MAX = 16'd20589;

	typedef struct packed {
		logic neg;
		logic flip;
	} gcd_tag_t;

	// Unsigned floor quotient by shift and subtract, one bit per pass.
	function automatic longint unsigned div_floor(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Arctangent of 2^-i in Q3.29, from the alternating series in Q62.
	function automatic logic [31:0] atan_q29(input int unsigned i);
		longint acc;
		longint unsigned term;
		int unsigned sh;
		longint r;
		acc = 0;
		if (i == 0) begin
			r = (PI48 + (64'sd1 <<< 20)) >>> 21;
		end else begin
			for (int unsigned k = 0; k < 64; k++) begin
				sh = i * (2 * k + 1);
				if (sh <= 62) begin
					term = div_floor(64'd1 << (62 - sh), 64'(2 * k + 1));
					if (k[0])
						acc = acc - longint'(term);
					else
						acc = acc + longint'(term);
				end
			end
			r = (acc + (64'sd1 <<< 32)) >>> 33;
		end
		return r[31:0];
	endfunction

endpackage

[rtl/gcd_sincos.sv]
// Degree-to-radian conversion followed by a pipelined rotation CORDIC.
module gcd_sincos (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [13:0]             h,
	input  gcd_pkg::gcd_tag_t       in_tag,
	output logic                    out_valid,
	output gcd_pkg::gcd_tag_t       out_tag,
	output logic signed [33:0]      cos_out,
	output logic signed [33:0]      sin_out
);

	localparam int S = gcd_pkg::STEPS;
	localparam logic [33:0] REM_W = 34'(gcd_pkg::RAD_REM);
	localparam logic [16:0] QUO_W = 17'(gcd_pkg::RAD_QUO);
	localparam logic [48:0] BIAS_W = 49'(gcd_pkg::RAD_BIAS);
	localparam logic [24:0] RECIP_W = 25'(gcd_pkg::RAD_RECIP);
	localparam logic signed [33:0] GAIN_W = 34'(gcd_pkg::GAIN);

	logic v_s1, v_s2, v_s3, v_s4;
	gcd_pkg::gcd_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [47:0] pr_s1;
	logic [30:0] pq_s1, pq_s2, pq_s3;
	logic [24:0] vq_s2;
	logic [49:0] w_s3;
	logic [29:0] ang_s4;

	logic signed [33:0] cx_s [1:S];
	logic signed [33:0] cy_s [1:S];
	logic signed [31:0] cz_s [1:S];
	logic               cv_s [1:S];
	gcd_pkg::gcd_tag_t  ct_s [1:S];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			pr_s1 <= 48'(h) * 48'(REM_W);
			pq_s1 <= 31'(h) * 31'(QUO_W);
			tag_s2 <= tag_s1;
			vq_s2 <= 25'((49'(pr_s1) + BIAS_W) >> 23);
			pq_s2 <= pq_s1;
			tag_s3 <= tag_s2;
			w_s3 <= 50'(vq_s2) * 50'(RECIP_W);
			pq_s3 <= pq_s2;
			tag_s4 <= tag_s3;
			ang_s4 <= 30'(pq_s3) + 30'(w_s3[49:35]);
		end
	end

	for (genvar i = 0; i < S; i++) begin : g_rot
		localparam logic signed [31:0] ATAN = signed'(gcd_pkg::atan_q29(i));
		logic signed [33:0] xi, yi;
		logic signed [31:0] zi;
		logic vi;
		gcd_pkg::gcd_tag_t ti;

		if (i == 0) begin : g_first
			assign xi = GAIN_W;
			assign yi = '0;
			assign zi = signed'({2'b00, ang_s4});
			assign vi = v_s4;
			assign ti = tag_s4;
		end else begin : g_next
			assign xi = cx_s[i];
			assign yi = cy_s[i];
			assign zi = cz_s[i];
			assign vi = cv_s[i];
			assign ti = ct_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ct_s[i+1] <= ti;
				if (!zi[31]) begin
					cx_s[i+1] <= xi - (yi >>> i);
					cy_s[i+1] <= yi + (xi >>> i);
					cz_s[i+1] <= zi - ATAN;
				end else begin
					cx_s[i+1] <= xi + (yi >>> i);
					cy_s[i+1] <= yi - (xi >>> i);
					cz_s[i+1] <= zi + ATAN;
				end
			end
		end
	end

	assign out_valid = cv_s[S];
	assign out_tag = ct_s[S];
	assign cos_out = cx_s[S];
	assign sin_out = cy_s[S];

endmodule

[rtl/gcd_acos.sv]
// Pipelined arccosine: integer square root, then a vectoring CORDIC and clamp.
module gcd_acos (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  c,
	output logic                out_valid,
	output logic [30:0]         theta
);

	localparam int S = gcd_pkg::STEPS;
	localparam int R = gcd_pkg::ROOT_STEPS;
	localparam logic [60:0] ONE_SQ = 61'd1 << 60;
	localparam logic signed [31:0] HALF_PI_W = 32'(gcd_pkg::HALF_PI);
	localparam logic [30:0] PI_W = 31'(gcd_pkg::PI_Q29);

	logic v_s1, v_s2, v_s3, v_s4;
	logic neg_s1, neg_s2, neg_s3;
	logic [30:0] a_s1, a_s2, a_s3;
	logic [61:0] sq_s2;
	logic [61:0] rem_s3;
	logic [30:0] theta_s4;

	logic [61:0] rv_s [1:R];
	logic [61:0] rr_s [1:R];
	logic [30:0] ra_s [1:R];
	logic        rn_s [1:R];
	logic        rval_s [1:R];

	logic signed [34:0] vx_s [1:S];
	logic signed [34:0] vy_s [1:S];
	logic signed [31:0] vz_s [1:S];
	logic               vn_s [1:S];
	logic               vval_s [1:S];

	logic signed [31:0] zc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= vval_s[S];
		end
	end

	always_comb begin
		zc = vz_s[S];
		if (vz_s[S][31])
			zc = '0;
		else if (vz_s[S] > HALF_PI_W)
			zc = HALF_PI_W;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= c[31];
			a_s1 <= c[31] ? 31'(-c) : c[30:0];
			neg_s2 <= neg_s1;
			a_s2 <= a_s1;
			sq_s2 <= 62'(a_s1) * 62'(a_s1);
			neg_s3 <= neg_s2;
			a_s3 <= a_s2;
			rem_s3 <= 62'(ONE_SQ) - sq_s2;
			theta_s4 <= vn_s[S] ? (PI_W - 31'(zc)) : 31'(zc);
		end
	end

	for (genvar j = 0; j < R; j++) begin : g_root
		localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
		logic [61:0] vi, ri, trial;
		logic [30:0] ai;
		logic ni, li;

		if (j == 0) begin : g_first
			assign vi = rem_s3;
			assign ri = '0;
			assign ai = a_s3;
			assign ni = neg_s3;
			assign li = v_s3;
		end else begin : g_next
			assign vi = rv_s[j];
			assign ri = rr_s[j];
			assign ai = ra_s[j];
			assign ni = rn_s[j];
			assign li = rval_s[j];
		end

		assign trial = ri + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rval_s[j+1] <= 1'b0;
			end else if (en) begin
				rval_s[j+1] <= li;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[j+1] <= ai;
				rn_s[j+1] <= ni;
				if (vi >= trial) begin
					rv_s[j+1] <= vi - trial;
					rr_s[j+1] <= (ri >> 1) + BIT;
				end else begin
					rv_s[j+1] <= vi;
					rr_s[j+1] <= ri >> 1;
				end
			end
		end
	end

	for (genvar i = 0; i < S; i++) begin : g_vec
		localparam logic signed [31:0] ATAN = signed'(gcd_pkg::atan_q29(i));
		logic signed [34:0] xi, yi;
		logic signed [31:0] zi;
		logic ni, li;

		if (i == 0) begin : g_first
			assign xi = signed'({4'b0000, ra_s[R]});
			assign yi = signed'({4'b0000, rr_s[R][30:0]});
			assign zi = '0;
			assign ni = rn_s[R];
			assign li = rval_s[R];
		end else begin : g_next
			assign xi = vx_s[i];
			assign yi = vy_s[i];
			assign zi = vz_s[i];
			assign ni = vn_s[i];
			assign li = vval_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vval_s[i+1] <= 1'b0;
			end else if (en) begin
				vval_s[i+1] <= li;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vn_s[i+1] <= ni;
				if (yi > 35'sd0) begin
					vx_s[i+1] <= xi + (yi >>> i);
					vy_s[i+1] <= yi - (xi >>> i);
					vz_s[i+1] <= zi + ATAN;
				end else begin
					vx_s[i+1] <= xi - (yi >>> i);
					vy_s[i+1] <= yi + (xi >>> i);
					vz_s[i+1] <= zi - ATAN;
				end
			end
		end
	end

	assign out_valid = v_s4;
	assign theta = theta_s4;

endmodule

[rtl/great_circle_distance.sv]
// Great-circle distance by the spherical law of cosines, fully pipelined.
// One request is taken every cycle while the result is not held; the two unrolled
// CORDIC chains and the root set the depth.
// A held result stalls the pipeline only when its last stage holds a request.
// Reset clears all valid bits and loads the radius register with 63781.
`include "great_circle_distance_macros.svh"

module great_circle_distance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// lat_first [14:0], lon_first [30:15], lat_second [45:31], lon_second [61:46]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// distance_km [14:0]
	output logic [15:0] m_tdata
);

	typedef struct packed {
		logic [13:0] h;
		gcd_pkg::gcd_tag_t tag;
	} gcd_fold_t;

	localparam logic [47:0] DBIAS_W = 48'(gcd_pkg::DIST_BIAS);
	localparam logic [18:0] DRECIP_W = 19'(gcd_pkg::DIST_RECIP);

	logic adv;
	logic [15:0] radius_q;
	logic out_valid_q;
	logic [14:0] dist_q;

	logic v_s1;
	gcd_fold_t f1_s1, f2_s1, fd_s1;

	logic sv1, sv2, sv3;
	gcd_pkg::gcd_tag_t st1, st2, st3;
	logic signed [33:0] c1, s1, c2, s2, cd, sd;
	logic signed [33:0] co1, si1, co2, si2, cdf;

	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [67:0] cc_s2, ss_s2, ss_s3, ss_s4;
	logic signed [33:0] cd_s2, cd_s3;
	logic signed [35:0] t_s3;
	logic signed [69:0] q_s4;
	logic signed [31:0] sum_s5;
	logic signed [39:0] sum_w;
	logic acos_v;
	logic [30:0] theta;
	logic [46:0] num_s6;
	logic [17:0] u_s7;
	logic [37:0] dprod;

	function automatic gcd_fold_t fold_lat(input logic [14:0] lat);
		logic [14:0] ab;
		gcd_fold_t r;
		ab = lat[14] ? (~lat + 15'd1) : lat;
		r.tag.neg = lat[14];
		r.tag.flip = 1'b0;
		if (ab > 15'd9000) begin
			r.tag.flip = 1'b1;
			r.h = 14'(15'd18000 - ab);
		end else begin
			r.h = ab[13:0];
		end
		return r;
	endfunction

	function automatic gcd_fold_t fold_lon(input logic [15:0] l1, input logic [15:0] l2);
		logic [16:0] d;
		logic [15:0] m;
		gcd_fold_t r;
		d = {1'b0, l1} - {1'b0, l2};
		m = d[16] ? 16'(-d) : d[15:0];
		if (m >= 16'd36000)
			m = m - 16'd36000;
		if (m > 16'd18000)
			m = 16'd36000 - m;
		r.tag.neg = 1'b0;
		r.tag.flip = 1'b0;
		if (m > 16'd9000) begin
			m = 16'd18000 - m;
			r.tag.flip = 1'b1;
		end
		r.h = m[13:0];
		return r;
	endfunction

	assign adv = !v_s7 || !out_valid_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gcd_pkg::RADIUS_RESET;
		end else if (cfg_wen) begin
			radius_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= s_tvalid;
				v_s2 <= sv1 && sv2 && sv3;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= acos_v;
				v_s7 <= v_s6;
			end
			if (adv && v_s7)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f1_s1 <= fold_lat(s_tdata[14:0]);
			f2_s1 <= fold_lat(s_tdata[45:31]);
			fd_s1 <= fold_lon(s_tdata[30:15], s_tdata[61:46]);
		end
	end

	gcd_sincos u_sc_first (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.h(f1_s1.h), .in_tag(f1_s1.tag),
		.out_valid(sv1), .out_tag(st1), .cos_out(c1), .sin_out(s1)
	);

	gcd_sincos u_sc_second (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.h(f2_s1.h), .in_tag(f2_s1.tag),
		.out_valid(sv2), .out_tag(st2), .cos_out(c2), .sin_out(s2)
	);

	gcd_sincos u_sc_delta (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.h(fd_s1.h), .in_tag(fd_s1.tag),
		.out_valid(sv3), .out_tag(st3), .cos_out(cd), .sin_out(sd)
	);

	assign co1 = st1.flip ? -c1 : c1;
	assign si1 = st1.neg ? -s1 : s1;
	assign co2 = st2.flip ? -c2 : c2;
	assign si2 = st2.neg ? -s2 : s2;
	assign cdf = (st3.flip ^ st3.neg) ? -cd : cd;

	assign sum_w = 40'((q_s4 + 70'(ss_s4) + 70'sh20000000) >>> 30);
	assign dprod = 38'(u_s7) * 38'(DRECIP_W);

	always_ff @(posedge clk) begin
		if (adv) begin
			cc_s2 <= 68'(co1) * 68'(co2);
			ss_s2 <= 68'(si1) * 68'(si2);
			cd_s2 <= cdf;
			t_s3 <= 36'((cc_s2 + 68'sh20000000) >>> 30);
			ss_s3 <= ss_s2;
			cd_s3 <= cd_s2;
			q_s4 <= 70'(t_s3) * 70'(cd_s3);
			ss_s4 <= ss_s3;
			if (sum_w > 40'sd1073741824)
				sum_s5 <= 32'sd1073741824;
			else if (sum_w < -40'sd1073741824)
				sum_s5 <= -32'sd1073741824;
			else
				sum_s5 <= 32'(sum_w);
			num_s6 <= 47'(theta) * 47'(radius_q);
			u_s7 <= 18'((48'(num_s6) + DBIAS_W) >> 30);
		end
		if (adv && v_s7)
			dist_q <= 15'(dprod >> 21);
	end

	gcd_acos u_acos (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s5),
		.c(sum_s5), .out_valid(acos_v), .theta(theta)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, dist_q};

	`GCD_ASSERT_IMPL(a_dist_range, out_valid_q, ({1'b0, dist_q} <= gcd_pkg::DIST_MAX), "distance beyond half circumference")
	`GCD_ASSERT_IMPL(a_sum_sat, v_s5, ((sum_s5 <= 32'sd1073741824) && (sum_s5 >= -32'sd1073741824)), "cosine not saturated")
	`GCD_ASSERT_NEVER(a_theta_range, acos_v && (theta > 31'(gcd_pkg::PI_Q29)), "arccos result above pi")

endmodule

[tb/great_circle_distance_tb.sv]
// Self-checking testbench for the great-circle distance pipeline with a fixed-point predictor.
`timescale 1ns / 1ps

module great_circle_distance_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 160;
	localparam longint ONE_Q30 = 64'sd1 <<< 30;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	great_circle_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	logic [63:0] pending_req_q[$];
	logic [14:0] expected_dist_q[$];
	longint atan_tab[0:60];
	logic [15:0] radius_now;
	int n_steps;
	int mismatches;
	int dist_seen;
	int req_sent;
	int cycles;
	bit in_burst_s;
	bit in_burst_m;
	int gap_s;
	int gap_m;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint atan_entry(int i);
		longint acc;
		longint unsigned term;
		int sh;
		acc = 0;
		if (i == 0)
			return (gcd_pkg::PI48 + (64'sd1 <<< 20)) >>> 21;
		for (int k = 0; k < 64; k++) begin
			sh = i * (2 * k + 1);
			if (sh <= 62) begin
				term = (64'd1 << (62 - sh)) / longint'(2 * k + 1);
				acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
		end
		return (acc + (64'sd1 <<< 32)) >>> 33;
	endfunction

	function automatic longint hundredths_to_rad(longint h);
		return (h * gcd_pkg::PI48 + 64'sd9000 * 64'sd524288) / (64'sd18000 * 64'sd524288);
	endfunction

	function automatic void rotate_sin_cos(longint ang, output longint co, output longint si);
		longint x, y, z, xs, ys;
		x = gcd_pkg::GAIN;
		y = 0;
		z = ang;
		for (int i = 0; i < n_steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= atan_tab[i];
			end else begin
				x += ys;
				y -= xs;
				z += atan_tab[i];
			end
		end
		co = x;
		si = y;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint central_angle(longint c);
		longint a, x, y, z, xs, ys;
		a = (c < 0) ? -c : c;
		x = a;
		z = 0;
		y = longint'(floor_sqrt(64'(ONE_Q30 * ONE_Q30) - 64'(a * a)));
		for (int i = 0; i < n_steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += atan_tab[i];
			end else begin
				x -= ys;
				y += xs;
				z -= atan_tab[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > gcd_pkg::HALF_PI)
			z = gcd_pkg::HALF_PI;
		return (c < 0) ? gcd_pkg::PI_Q29 - z : z;
	endfunction

	function automatic void latitude_trig(logic signed [14:0] lat, output longint co,
		output longint si);
		longint a, c, s;
		bit flip;
		a = (lat < 0) ? -longint'(lat) : longint'(lat);
		flip = 0;
		if (a > 9000) begin
			a = 18000 - a;
			flip = 1;
		end
		rotate_sin_cos(hundredths_to_rad(a), c, s);
		co = flip ? -c : c;
		si = (lat < 0) ? -s : s;
	endfunction

	function automatic logic [14:0] predict_distance(logic [63:0] req);
		longint c1, s1, c2, s2, cd, sd, m, t, sum;
		longint unsigned num;
		bit flip;
		latitude_trig(req[14:0], c1, s1);
		latitude_trig(req[45:31], c2, s2);
		m = longint'(req[30:15]) - longint'(req[61:46]);
		if (m < 0)
			m = -m;
		m %= 36000;
		if (m > 18000)
			m = 36000 - m;
		flip = 0;
		if (m > 9000) begin
			m = 18000 - m;
			flip = 1;
		end
		rotate_sin_cos(hundredths_to_rad(m), cd, sd);
		if (flip)
			cd = -cd;
		t = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
		sum = (t * cd + s1 * s2 + (64'sd1 <<< 29)) >>> 30;
		if (sum > ONE_Q30)
			sum = ONE_Q30;
		if (sum < -ONE_Q30)
			sum = -ONE_Q30;
		num = 64'(central_angle(sum)) * 64'(radius_now);
		return 15'((num + 64'd5 * 64'd536870912) / (64'd10 * 64'd536870912));
	endfunction

	function automatic logic [63:0] pack_req(int lat1, int lon1, int lat2, int lon2);
		logic [14:0] la1, la2;
		logic [15:0] lo1, lo2;
		la1 = 15'(lat1);
		la2 = 15'(lat2);
		lo1 = 16'(lon1);
		lo2 = 16'(lon2);
		return {2'b00, lo2, la2, lo1, la1};
	endfunction

	function automatic logic [63:0] random_req();
		if ($urandom_range(0, 9) == 0)
			return {2'b00, 62'({$urandom, $urandom})};
		return pack_req($urandom_range(0, 18000) - 9000, $urandom_range(0, 36000),
			$urandom_range(0, 18000) - 9000, $urandom_range(0, 36000));
	endfunction

	// The request side draws a fresh gap after each request, with some zero-gap bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_s = 0;
			in_burst_s = 0;
			req_sent = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_dist_q.push_back(predict_distance(s_tdata));
				req_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_s != 0) begin
					gap_s--;
					s_tvalid <= 1'b0;
				end else if (pending_req_q.size() != 0) begin
					s_tdata <= pending_req_q.pop_front();
					s_tvalid <= 1'b1;
					if ($urandom_range(0, 29) == 0)
						in_burst_s = !in_burst_s;
					gap_s = in_burst_s ? 0 : $urandom_range(0, 15);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			gap_m = 0;
			in_burst_m = 0;
			mismatches = 0;
			dist_seen = 0;
			cycles = 0;
		end else begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles.", cycles);
				$display("*** FAILED ***");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				dist_seen++;
				if (expected_dist_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result %0d.", m_tdata);
				end else begin
					logic [14:0] want;
					want = expected_dist_q.pop_front();
					if (m_tdata !== {1'b0, want}) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result %0d: distance_km expected %0d, got %0d.",
								dist_seen, want, m_tdata);
					end
				end
			end
			if (gap_m != 0) begin
				gap_m--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid) begin
					if ($urandom_range(0, 29) == 0)
						in_burst_m = !in_burst_m;
					gap_m = in_burst_m ? 0 : $urandom_range(0, 15);
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_req_q.size() != 0 || s_tvalid || expected_dist_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_radius(logic [15:0] r);
		cfg_wen <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		radius_now = r;
		cfg_wen <= 1'b0;
	endtask

	initial begin
		logic [15:0] radii[6];
		n_steps = gcd_pkg::STEPS;
		for (int i = 0; i <= 60; i++)
			atan_tab[i] = atan_entry(i);
		radius_now = gcd_pkg::RADIUS_RESET;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_req_q.push_back(pack_req(0, 0, 0, 0));
		pending_req_q.push_back(pack_req(0, 0, 0, 18000));
		pending_req_q.push_back(pack_req(9000, 0, -9000, 0));
		pending_req_q.push_back(pack_req(9000, 12345, 9000, 100));
		pending_req_q.push_back(pack_req(-9000, 36000, 4500, 0));
		pending_req_q.push_back(pack_req(4512, 1000, -3321, 13000));
		pending_req_q.push_back(pack_req(1000, 0, 1000, 27000));
		pending_req_q.push_back(pack_req(0, 0, 0, 9000));
		pending_req_q.push_back(pack_req(0, 9001, 0, 0));
		pending_req_q.push_back(pack_req(12000, 500, -12000, 700));
		pending_req_q.push_back(pack_req(-16384, 0, 16383, 65535));
		pending_req_q.push_back(pack_req(16383, 65535, -16384, 0));
		pending_req_q.push_back(pack_req(3000, 65535, 3000, 0));
		pending_req_q.push_back(pack_req(-9000, 50000, 9000, 1));
		pending_req_q.push_back(pack_req(5000, 36000, 5000, 0));
		pending_req_q.push_back(pack_req(1, 0, 0, 1));
		pending_req_q.push_back(pack_req(18000, 0, -18000, 18000));
		wait_idle();

		radii = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(1, 65535)), 16'd6000,
			gcd_pkg::RADIUS_RESET};
		for (int p = 0; p < 6; p++) begin
			write_radius(radii[p]);
			for (int n = 0; n < 75; n++)
				pending_req_q.push_back(random_req());
			wait_idle();
		end

		$display("Sent %0d requests over seven radius settings", req_sent);
		$display("(reset, 1, 65535, 0, random, 6000, reset); checked %0d, %0d mismatches.",
			dist_seen, mismatches);
		if (mismatches == 0 && expected_dist_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
